// ===== design/thermistor_periodic_reporter_defines.svh =====
// Assertion macros used by the reporter's top level.
`ifndef THERMISTOR_PERIODIC_REPORTER_DEFINES_SVH
`define THERMISTOR_PERIODIC_REPORTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TPR_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TPR_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== design/tpr_pkg.sv =====
// Types, constants and conversion tables of the thermistor periodic reporter.
package tpr_pkg;

  localparam int MAX_LINE_DEF = 64;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_REPORT   = 2'd0,
    KIND_SHUTDOWN = 2'd1,
    KIND_ERROR    = 2'd2
  } kind_t;

  // One result request travelling from the front to the back.
  typedef struct packed {
    kind_t      kind;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] reading;
    logic       scale;
  } req_t;

  // Status of the front, for checking.
  typedef struct packed {
    logic push;
    logic halted;
  } front_status_t;

  typedef logic signed [13:0] temp_tbl_t [1024];

  function automatic longint log2_q24(longint n);
    longint k;
    longint frac;
    longint x;
    k = 0;
    frac = 0;
    for (int i = 0; i < 9; i++) begin
      if ((n >> (i + 1)) != 0) k = i + 1;
    end
    x = n << (30 - k);
    for (int i = 23; i >= 0; i--) begin
      x = (x * x) >>> 30;
      if (x >= (64'sd2 <<< 30)) begin
        x = x >>> 1;
        frac = frac | (64'sd1 <<< i);
      end
    end
    return (k <<< 24) | frac;
  endfunction

  // Signed quotient truncated toward zero, by shift and subtract.
  function automatic longint div_trunc(longint a, longint b);
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] q;
    logic [64:0] rem;
    bit          neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    q = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], ua[i]};
      if (rem >= {1'b0, ub}) begin
        rem = rem - {1'b0, ub};
        q[i] = 1'b1;
      end
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [13:0] temp_of(int r, bit celsius);
    longint d;
    longint m;
    longint p;
    longint l;
    longint den;
    longint num;
    longint res;
    num = 64'sd1274591250 * 64'sd16777216;
    if (r == 0 || r >= 1023) begin
      res = celsius ? -2731 : -4596;
    end else begin
      d = log2_q24(longint'(1023 - r)) - log2_q24(longint'(r));
      m = (d < 0) ? -d : d;
      p = (m * 64'sd2977044472) >>> 32;
      l = (d < 0) ? -p : p;
      den = l * 29815 + 64'sd427500 * 64'sd16777216;
      if (celsius) res = div_trunc(num - 2731 * den, den);
      else res = div_trunc(18 * num - 45962 * den, 10 * den);
    end
    return res[13:0];
  endfunction

  function automatic temp_tbl_t build_tbl(bit celsius);
    temp_tbl_t t;
    for (int r = 0; r < 1024; r++) t[r] = temp_of(r, celsius);
    return t;
  endfunction

  localparam temp_tbl_t TEMP_TBL_C = build_tbl(1'b1);
  localparam temp_tbl_t TEMP_TBL_F = build_tbl(1'b0);

endpackage

// ===== design/tpr_front.sv =====
// Front part: accepts items, matches command lines, keeps timing state.
module tpr_front #(
  parameter int MAX_LINE = tpr_pkg::MAX_LINE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  command,
  input  logic [31:0]           epoch_sec,
  input  logic [4:0]            hour,
  input  logic [5:0]            minute,
  input  logic [5:0]            second,
  input  logic [9:0]            adc_reading,
  input  logic [7:0]            rx_byte,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data,
  output logic                  push,
  output tpr_pkg::req_t         req,
  output tpr_pkg::front_status_t status
);

  localparam int LW = $clog2(MAX_LINE + 1);
  localparam int NP = 7;
  localparam int P_SCALE_F = 0;
  localparam int P_SCALE_C = 1;
  localparam int P_PERIOD  = 2;
  localparam int P_STOP    = 3;
  localparam int P_START   = 4;
  localparam int P_LOG     = 5;
  localparam int P_OFF     = 6;
  localparam logic [7:0] PAT [NP][8] = '{
    '{"S", "C", "A", "L", "E", "=", "F", 8'h00},
    '{"S", "C", "A", "L", "E", "=", "C", 8'h00},
    '{"P", "E", "R", "I", "O", "D", "=", 8'h00},
    '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "T", "A", "R", "T", 8'h00, 8'h00, 8'h00},
    '{"L", "O", "G", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int PLEN [NP] = '{7, 7, 7, 4, 5, 3, 3};
  localparam logic [NP-1:0] PREFIX = NP'((1 << P_PERIOD) | (1 << P_LOG));

  typedef enum logic [2:0] {
    PH_WS    = 3'b001,
    PH_DIGIT = 3'b010,
    PH_DONE  = 3'b100
  } phase_t;

  logic            scale_celsius, scale_celsius_next;
  logic [15:0]     report_period, report_period_next;
  logic            reporting_on, reporting_on_next;
  logic [31:0]     last_report_sec, last_report_sec_next;
  logic            have_reference, have_reference_next;
  logic [LW-1:0]   line_length, line_length_next;
  logic            halted, halted_next;
  logic [NP-1:0]   match, match_next;
  phase_t          phase, phase_next;
  logic [16:0]     pval, pval_next;
  logic            pneg, pneg_next;

  logic            is_ws, is_sign, is_digit;
  logic [19:0]     acc;
  logic [31:0]     ref_sec;
  logic [15:0]     parsed;

  always_comb begin
    is_ws = (rx_byte == 8'h20) || (rx_byte == 8'h09) || (rx_byte == 8'h0B) ||
            (rx_byte == 8'h0C) || (rx_byte == 8'h0D);
    is_sign = (rx_byte == "+") || (rx_byte == "-");
    is_digit = (rx_byte >= "0") && (rx_byte <= "9");
    acc = 20'(pval) * 20'd10 + 20'(rx_byte - "0");
    ref_sec = have_reference ? last_report_sec : epoch_sec;
    parsed = pneg ? 16'd0 : (pval[16] ? 16'hFFFF : pval[15:0]);
  end

  always_comb begin
    scale_celsius_next = scale_celsius;
    report_period_next = report_period;
    reporting_on_next = reporting_on;
    last_report_sec_next = last_report_sec;
    have_reference_next = have_reference;
    line_length_next = line_length;
    halted_next = halted;
    match_next = match;
    phase_next = phase;
    pval_next = pval;
    pneg_next = pneg;
    push = 1'b0;
    req.kind = tpr_pkg::KIND_REPORT;
    req.hour = hour;
    req.minute = minute;
    req.second = second;
    req.reading = adc_reading;
    req.scale = scale_celsius;

    if (cfg_we) begin
      if (cfg_index) report_period_next = cfg_data;
      else scale_celsius_next = cfg_data[0];
    end

    if (accept && !halted) begin
      if (!command) begin
        last_report_sec_next = ref_sec;
        have_reference_next = 1'b1;
        if (reporting_on &&
            {1'b0, epoch_sec} >= {1'b0, ref_sec} + {17'd0, report_period}) begin
          push = 1'b1;
          last_report_sec_next = epoch_sec;
        end
      end else if (rx_byte == 8'h0A) begin
        // Priority follows the command order: first match wins.
        if (match[P_SCALE_F] && line_length == LW'(PLEN[P_SCALE_F])) begin
          scale_celsius_next = 1'b0;
        end else if (match[P_SCALE_C] && line_length == LW'(PLEN[P_SCALE_C])) begin
          scale_celsius_next = 1'b1;
        end else if (match[P_PERIOD] && line_length >= LW'(PLEN[P_PERIOD])) begin
          report_period_next = parsed;
        end else if (match[P_STOP] && line_length == LW'(PLEN[P_STOP])) begin
          reporting_on_next = 1'b0;
        end else if (match[P_START] && line_length == LW'(PLEN[P_START])) begin
          reporting_on_next = 1'b1;
        end else if (match[P_LOG] && line_length >= LW'(PLEN[P_LOG])) begin
          halted_next = 1'b0;
        end else if (match[P_OFF] && line_length == LW'(PLEN[P_OFF])) begin
          push = 1'b1;
          req.kind = tpr_pkg::KIND_SHUTDOWN;
          halted_next = 1'b1;
        end else begin
          push = 1'b1;
          req.kind = tpr_pkg::KIND_ERROR;
          halted_next = 1'b1;
        end
        line_length_next = '0;
        match_next = '1;
        phase_next = PH_WS;
        pval_next = '0;
        pneg_next = 1'b0;
      end else if (line_length < LW'(MAX_LINE)) begin
        line_length_next = line_length + LW'(1);
        for (int i = 0; i < NP; i++) begin
          if (line_length < LW'(PLEN[i])) begin
            if (rx_byte != PAT[i][line_length[2:0]]) match_next[i] = 1'b0;
          end else if (!PREFIX[i]) begin
            match_next[i] = 1'b0;
          end
        end
        // The number after PERIOD= is read as its characters arrive.
        if (line_length >= LW'(PLEN[P_PERIOD])) begin
          case (phase)
            PH_WS: begin
              if (is_sign) begin
                pneg_next = (rx_byte == "-");
                phase_next = PH_DIGIT;
              end else if (is_digit) begin
                pval_next = 17'(acc);
                phase_next = PH_DIGIT;
              end else if (!is_ws) begin
                phase_next = PH_DONE;
              end
            end
            PH_DIGIT: begin
              if (is_digit) pval_next = (acc > 20'd65535) ? 17'h10000 : 17'(acc);
              else phase_next = PH_DONE;
            end
            default: phase_next = PH_DONE;
          endcase
        end
      end else begin
        push = 1'b1;
        req.kind = tpr_pkg::KIND_ERROR;
        halted_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_celsius <= 1'b0;
      report_period <= 16'd1;
      reporting_on <= 1'b1;
      last_report_sec <= '0;
      have_reference <= 1'b0;
      line_length <= '0;
      halted <= 1'b0;
      match <= '1;
      phase <= PH_WS;
      pval <= '0;
      pneg <= 1'b0;
    end else begin
      scale_celsius <= scale_celsius_next;
      report_period <= report_period_next;
      reporting_on <= reporting_on_next;
      last_report_sec <= last_report_sec_next;
      have_reference <= have_reference_next;
      line_length <= line_length_next;
      halted <= halted_next;
      match <= match_next;
      phase <= phase_next;
      pval <= pval_next;
      pneg <= pneg_next;
    end
  end

  assign status.push = push;
  assign status.halted = halted;

endmodule

// ===== design/tpr_queue.sv =====
// Short request queue between the front and the back.
module tpr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tpr_pkg::req_t push_req,
  input  logic          pop,
  output tpr_pkg::req_t head,
  output logic          empty,
  output logic          full
);

  localparam int D = tpr_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(D);

  tpr_pkg::req_t entries [D];
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;
  logic [AW:0]   count;

  assign empty = (count == '0);
  assign full = (count == (AW+1)'(D));
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop) rd_ptr <= rd_ptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== design/tpr_back.sv =====
// Back part: converts readings by table and holds the result register.
module tpr_back (
  input  logic               clk,
  input  logic               rst,
  input  tpr_pkg::req_t      head,
  input  logic               empty,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         kind,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second,
  output logic signed [13:0] temp_tenths,
  output logic               scale_used,
  output logic               reading_invalid
);

  logic               is_report;
  logic signed [13:0] temp;

  assign pop = !empty && (!out_valid || !out_stall);
  assign is_report = (head.kind == tpr_pkg::KIND_REPORT);

  always_comb begin
    if (!is_report) temp = '0;
    else if (head.scale) temp = tpr_pkg::TEMP_TBL_C[head.reading];
    else temp = tpr_pkg::TEMP_TBL_F[head.reading];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= head.kind;
      out_hour <= head.hour;
      out_minute <= head.minute;
      out_second <= head.second;
      temp_tenths <= temp;
      scale_used <= head.scale;
      reading_invalid <= is_report && (head.reading == 10'd0);
    end
  end

endmodule

// ===== design/thermistor_periodic_reporter.sv =====
// A result passes through a queue entry and then the output register before it is on the outputs.
// Throughput: one item per cycle; the four-entry queue ahead of the output
// register stalls input only when full while output is stalled.
// Reset (rst, synchronous): scale Fahrenheit, period 1, reporting on, line empty.
// Configuration writes are taken every cycle.
// Top level of the thermistor periodic reporter.
`include "thermistor_periodic_reporter_defines.svh"

module thermistor_periodic_reporter #(
  parameter int MAX_LINE = tpr_pkg::MAX_LINE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [31:0]        epoch_sec,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  input  logic [9:0]         adc_reading,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second,
  output logic signed [13:0] temp_tenths,
  output logic               scale_used,
  output logic               reading_invalid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  logic                   accept;
  logic                   push;
  logic                   pop;
  logic                   empty;
  logic                   full;
  tpr_pkg::req_t          req;
  tpr_pkg::req_t          head;
  tpr_pkg::front_status_t status;

  assign cfg_ready = 1'b1;
  assign in_stall = full;
  assign accept = in_valid && !in_stall;

  tpr_front #(.MAX_LINE(MAX_LINE)) u_front (
    .clk, .rst, .accept, .command, .epoch_sec, .hour, .minute, .second,
    .adc_reading, .rx_byte,
    .cfg_we(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .push, .req, .status
  );

  tpr_queue u_queue (
    .clk, .rst, .push, .push_req(req), .pop, .head, .empty, .full
  );

  tpr_back u_back (
    .clk, .rst, .head, .empty, .pop, .out_stall, .out_valid, .kind,
    .out_hour, .out_minute, .out_second, .temp_tenths, .scale_used,
    .reading_invalid
  );

  `TPR_ASSERT_NEXT(a_halt_after_final, clk, rst, status.push && req.kind != tpr_pkg::KIND_REPORT, status.halted, "no halt after shutdown or error request")
  `TPR_ASSERT_NEXT(a_halt_sticks, clk, rst, status.halted, status.halted && !status.push, "halted front resumed")
  `TPR_ASSERT_NOW(a_invalid_only_report, clk, rst, out_valid && reading_invalid, kind == tpr_pkg::KIND_REPORT, "invalid flag on a non-report result")

endmodule

// ===== test/thermistor_periodic_reporter_test.sv =====
// Self-checking testbench of the thermistor periodic reporter.
module thermistor_periodic_reporter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic CFG_SCALE = 1'b0;
  localparam logic CFG_PERIOD = 1'b1;
  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam int NO_RESULT = -1;

  typedef struct {
    bit        is_byte;
    bit [31:0] epoch;
    bit [4:0]  hh;
    bit [5:0]  mm;
    bit [5:0]  ss;
    bit [9:0]  adc;
    bit [7:0]  rx;
  } request_t;

  typedef struct {
    tpr_pkg::kind_t     kind;
    bit [4:0]           hh;
    bit [5:0]           mm;
    bit [5:0]           ss;
    logic signed [13:0] temp;
    bit                 scale;
    bit                 invalid;
  } event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = 1'b0;
  logic [31:0] epoch_sec = '0;
  logic [4:0] hour = '0;
  logic [5:0] minute = '0;
  logic [5:0] second = '0;
  logic [9:0] adc_reading = '0;
  logic [7:0] rx_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic [4:0] out_hour;
  logic [5:0] out_minute;
  logic [5:0] out_second;
  logic signed [13:0] temp_tenths;
  logic scale_used;
  logic reading_invalid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  thermistor_periodic_reporter uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Temperature tables, built independently of the design.
  int celsius_tbl[1024];
  int fahrenheit_tbl[1024];

  // Mirror of the block's state.
  bit        m_celsius;
  bit [15:0] m_period;
  bit        m_on;
  bit [31:0] m_last;
  bit        m_have_ref;
  bit [7:0]  m_line[LINE_MAX];
  int        m_len;
  bit        m_halted;

  request_t pending[$];
  event_t   expected_events[$];
  request_t cur;
  bit       calm = 1'b0;
  int       hold_len = 0;
  int       gap = 0;
  int       stall_left = 0;
  int       fails = 0;
  int       n_acc = 0;
  int       n_res = 0;
  int       n_reports = 0;
  int       idle_cycles = 0;
  bit [31:0] cur_epoch = '0;

  function automatic longint log2_fixed(longint n);
    longint k;
    longint frac;
    longint x;
    k = 0;
    frac = 0;
    while (k < 9 && (n >> (k + 1)) != 0) k++;
    x = n << (30 - k);
    for (int i = 23; i >= 0; i--) begin
      x = (x * x) >> 30;
      if (x >= (64'sd2 << 30)) begin
        x = x >> 1;
        frac = frac | (64'sd1 << i);
      end
    end
    return (k << 24) | frac;
  endfunction

  function automatic int tenths_for_reading(int r, bit c);
    longint d;
    longint m;
    longint p;
    longint l;
    longint den;
    longint num;
    if (r == 0 || r >= 1023) return c ? -2731 : -4596;
    num = 64'sd1274591250 * 64'sd16777216;
    d = log2_fixed(1023 - r) - log2_fixed(r);
    m = (d < 0) ? -d : d;
    p = (m * 64'sd2977044472) >> 32;
    l = (d < 0) ? -p : p;
    den = l * 29815 + 64'sd427500 * 64'sd16777216;
    if (c) return int'((num - 2731 * den) / den);
    return int'((18 * num - 45962 * den) / (10 * den));
  endfunction

  function automatic bit line_has(string s, bit prefix);
    if (prefix ? (m_len < s.len()) : (m_len != s.len())) return 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if (m_line[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit [15:0] period_from_line();
    int i;
    int v;
    bit neg;
    i = 7;
    v = 0;
    neg = 1'b0;
    while (i < m_len && (m_line[i] == 8'h20 || (m_line[i] >= 8'h09 && m_line[i] <= 8'h0D
           && m_line[i] != NEWLINE))) i++;
    if (i < m_len && (m_line[i] == "+" || m_line[i] == "-")) begin
      neg = m_line[i] == "-";
      i++;
    end
    while (i < m_len && m_line[i] >= "0" && m_line[i] <= "9") begin
      v = v * 10 + (m_line[i] - "0");
      if (v > 65535) v = 65536;
      i++;
    end
    if (neg) return 16'd0;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic int execute_line();
    if (line_has("SCALE=F", 0)) m_celsius = 1'b0;
    else if (line_has("SCALE=C", 0)) m_celsius = 1'b1;
    else if (line_has("PERIOD=", 1)) m_period = period_from_line();
    else if (line_has("STOP", 0)) m_on = 1'b0;
    else if (line_has("START", 0)) m_on = 1'b1;
    else if (line_has("LOG", 1)) return NO_RESULT;
    else if (line_has("OFF", 0)) return tpr_pkg::KIND_SHUTDOWN;
    else return tpr_pkg::KIND_ERROR;
    return NO_RESULT;
  endfunction

  function automatic void predict_request(request_t q);
    int k;
    event_t e;
    k = NO_RESULT;
    e.temp = '0;
    e.invalid = 1'b0;
    if (m_halted) return;
    if (!q.is_byte) begin
      if (!m_have_ref) begin
        m_last = q.epoch;
        m_have_ref = 1'b1;
      end
      if (m_on && {1'b0, q.epoch} >= {1'b0, m_last} + m_period) begin
        k = tpr_pkg::KIND_REPORT;
        e.temp = 14'(m_celsius ? celsius_tbl[q.adc] : fahrenheit_tbl[q.adc]);
        e.invalid = q.adc == 0;
        m_last = q.epoch;
      end
    end else if (q.rx == NEWLINE) begin
      k = execute_line();
      m_len = 0;
      if (k != NO_RESULT) m_halted = 1'b1;
    end else if (m_len < LINE_MAX) begin
      m_line[m_len] = q.rx;
      m_len++;
    end else begin
      k = tpr_pkg::KIND_ERROR;
      m_halted = 1'b1;
    end
    if (k == NO_RESULT) return;
    e.kind = tpr_pkg::kind_t'(k);
    e.hh = q.hh;
    e.mm = q.mm;
    e.ss = q.ss;
    e.scale = m_celsius;
    expected_events.push_back(e);
  endfunction

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_request(cur);
        n_acc++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          command <= cur.is_byte;
          epoch_sec <= cur.epoch;
          hour <= cur.hh;
          minute <= cur.mm;
          second <= cur.ss;
          adc_reading <= cur.adc;
          rx_byte <= cur.rx;
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and checker.
  always @(posedge clk) begin
    event_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_res++;
        if (expected_events.size() == 0) begin
          $error("unexpected result, kind %0d", kind);
          fails++;
        end else begin
          e = expected_events.pop_front();
          if (e.kind == tpr_pkg::KIND_REPORT) n_reports++;
          if (kind != e.kind) begin
            $error("kind: expected %0d, actual %0d", e.kind, kind); fails++;
          end
          if (out_hour != e.hh) begin
            $error("out_hour: expected %0d, actual %0d", e.hh, out_hour); fails++;
          end
          if (out_minute != e.mm) begin
            $error("out_minute: expected %0d, actual %0d", e.mm, out_minute); fails++;
          end
          if (out_second != e.ss) begin
            $error("out_second: expected %0d, actual %0d", e.ss, out_second); fails++;
          end
          if (temp_tenths != e.temp) begin
            $error("temp_tenths: expected %0d, actual %0d", e.temp, temp_tenths); fails++;
          end
          if (scale_used != e.scale) begin
            $error("scale_used: expected %0d, actual %0d", e.scale, scale_used); fails++;
          end
          if (reading_invalid != e.invalid) begin
            $error("reading_invalid: expected %0d, actual %0d", e.invalid, reading_invalid);
            fails++;
          end
        end
      end
      if (hold_len > 0) begin
        hold_len--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any accepted transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("thermistor_periodic_reporter regression: fail");
        $finish;
      end
    end
  end

  function automatic void add_request(bit is_byte, bit [9:0] adc, bit [7:0] b);
    request_t q;
    q.is_byte = is_byte;
    if (cur_epoch < 32'hFFFF_FFF0) cur_epoch += $urandom_range(0, 3);
    q.epoch = cur_epoch;
    q.hh = 5'($urandom_range(0, 23));
    q.mm = 6'($urandom_range(0, 59));
    q.ss = 6'($urandom_range(0, 60));
    q.adc = adc;
    q.rx = b;
    pending.push_back(q);
  endfunction

  function automatic void add_line(string s);
    for (int i = 0; i < s.len(); i++) add_request(1'b1, 10'($urandom), s[i]);
    add_request(1'b1, 10'($urandom), NEWLINE);
  endfunction

  function automatic string period_text();
    case ($urandom_range(0, 7))
      4: return $sformatf(" \t%c%c%c+%0d", 8'h0B, 8'h0C, 8'h0D, $urandom_range(0, 6));
      5: return $sformatf("-%0d", $urandom_range(0, 99));
      6: return $sformatf("%0d", $urandom);
      7: return $sformatf("%0dz9", $urandom_range(0, 5));
      default: return $sformatf("%0d", $urandom_range(0, 4));
    endcase
  endfunction

  function automatic string log_text(int n);
    string s;
    bit [7:0] c;
    s = "LOG";
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(0, 255));
      if (c == NEWLINE) c = 8'hF5;
      s = $sformatf("%s%c", s, c);
    end
    return s;
  endfunction

  task automatic settle();
    while (pending.size() > 0 || in_valid || expected_events.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == CFG_SCALE) m_celsius = data[0];
    else m_period = data;
  endtask

  task automatic random_requests(int total);
    int n;
    n = 0;
    while (n < total) begin
      if (total - n < 120) calm = 1'b1;
      case ($urandom_range(0, 19))
        0: add_line("SCALE=F");
        1: add_line("SCALE=C");
        2: add_line("STOP");
        3, 4: add_line("START");
        5, 6: add_line({"PERIOD=", period_text()});
        7: add_line(log_text($urandom_range(0, 61)));
        default: add_request(1'b0, 10'($urandom_range(0, 1023)), 8'($urandom));
      endcase
      n = n + pending.size();
      while (pending.size() > 0) @(posedge clk);
    end
  endtask

  initial begin
    bit [15:0] periods[5];
    periods = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF};
    for (int r = 0; r < 1024; r++) begin
      celsius_tbl[r] = tenths_for_reading(r, 1'b1);
      fahrenheit_tbl[r] = tenths_for_reading(r, 1'b0);
    end
    m_celsius = 1'b0;
    m_period = 16'd1;
    m_on = 1'b1;
    m_last = '0;
    m_have_ref = 1'b0;
    m_len = 0;
    m_halted = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, the reading extremes, every command but OFF.
    add_request(1'b0, 10'd0, 8'h00);
    cur_epoch += 1;
    add_request(1'b0, 10'd1023, 8'hFF);
    cur_epoch += 1;
    add_request(1'b0, 10'd1, 8'h00);
    add_line("SCALE=C");
    cur_epoch += 2;
    add_request(1'b0, 10'd1022, 8'h00);
    add_line("PERIOD=0");
    add_request(1'b0, 10'd0, 8'h00);
    add_request(1'b0, 10'd512, 8'h00);
    add_line("STOP");
    add_request(1'b0, 10'd300, 8'h00);
    add_line("START");
    add_line("SCALE=F");
    add_line("LOG");
    add_request(1'b0, 10'd700, 8'h00);
    settle();

    // Many reports against a long output hold-off fill the queue.
    write_register(CFG_SCALE, 16'd1);
    write_register(CFG_PERIOD, 16'd0);
    hold_len = 300;
    for (int i = 0; i < 60; i++) add_request(1'b0, 10'($urandom_range(0, 1023)), 8'h00);
    settle();

    write_register(CFG_SCALE, 16'd0);
    write_register(CFG_PERIOD, 16'hFFFF);
    for (int i = 0; i < 5; i++) add_request(1'b0, 10'($urandom_range(0, 1023)), 8'h00);
    add_line("PERIOD=  +00002");
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      write_register(CFG_SCALE, 16'($urandom_range(0, 1)));
      write_register(CFG_PERIOD, periods[$urandom_range(0, 3)]);
      random_requests(phase == 3 ? 350 : 300);
      if (phase < 3) begin
        calm = 1'b0;
        settle();
      end
    end

    // Time near the top of its range, then a terminating line.
    cur_epoch = 32'hFFFF_FF00 + $urandom_range(0, 255);
    add_line("PERIOD=1");
    for (int i = 0; i < 8; i++) add_request(1'b0, 10'($urandom_range(0, 1023)), 8'h00);
    case ($urandom_range(0, 2))
      0: add_line("OFF");
      1: add_line("SCALE=X");
      default: add_line(log_text(70));
    endcase
    // The block is halted now and ignores everything.
    for (int i = 0; i < 10; i++) begin
      add_request(1'($urandom_range(0, 1)), 10'($urandom), 8'($urandom));
    end
    while (pending.size() > 0 || in_valid || expected_events.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d requests and checked %0d results, %0d of them reports,",
             n_acc, n_res, n_reports);
    $display("over both scales, period extremes, every command and a final halt.");
    if (fails == 0) begin
      $display("thermistor_periodic_reporter regression: pass");
    end else begin
      $display("thermistor_periodic_reporter regression: fail");
    end
    $finish;
  end

endmodule
